@@ rtl/dcgm_pkg.sv @@
// Shared types and constants for the dual-core GPIO and mailbox register block.
// Holds the access and response beat structs, register offsets and mailbox
// control/status structs. No dependencies.
package dcgm_pkg;

  // Default mailbox depth in words, per direction.
  localparam int DEFAULT_FIFO_DEPTH = 8;

  // Access kinds.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Register byte offsets.
  localparam logic [11:0] OFS_CPUID   = 12'h000;
  localparam logic [11:0] OFS_OUT     = 12'h010;
  localparam logic [11:0] OFS_OUT_SET = 12'h014;
  localparam logic [11:0] OFS_OUT_CLR = 12'h018;
  localparam logic [11:0] OFS_OUT_XOR = 12'h01c;
  localparam logic [11:0] OFS_OE      = 12'h020;
  localparam logic [11:0] OFS_OE_SET  = 12'h024;
  localparam logic [11:0] OFS_OE_CLR  = 12'h028;
  localparam logic [11:0] OFS_OE_XOR  = 12'h02c;
  localparam logic [11:0] OFS_FST     = 12'h050;
  localparam logic [11:0] OFS_FWR     = 12'h054;
  localparam logic [11:0] OFS_FRD     = 12'h058;
  localparam logic [11:0] OFS_SPIN    = 12'h05c;

  // Bit positions in the mailbox status word.
  localparam int ST_VLD_BIT = 0;
  localparam int ST_RDY_BIT = 1;
  localparam int ST_WOF_BIT = 2;
  localparam int ST_ROE_BIT = 3;

  // One register access.
  typedef struct packed {
    logic        command;
    logic        requesting_core;
    logic [11:0] reg_offset;
    logic [31:0] write_data;
  } req_item_t;

  // One access result.
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_core0;
    logic        irq_core1;
    logic        wake_core0;
    logic        wake_core1;
    logic        bad_offset;
  } rsp_item_t;

  // Operation requested of one mailbox; push and pop are already qualified.
  typedef struct packed {
    logic        push;
    logic        pop;
    logic [31:0] wdata;
  } mbox_ctrl_t;

  // Mailbox status seen by the decode logic.
  typedef struct packed {
    logic        not_empty;
    logic        not_full;
    logic        not_empty_next;
    logic [31:0] head_word;
  } mbox_stat_t;

endpackage

@@ rtl/dual_core_gpio_and_mailbox_regs.sv @@
// Top level of the dual-core GPIO and mailbox register block.
// Depends on dcgm_pkg and dcgm_mailbox.
//
// Usage:
//   Each beat on the req channel is one 32-bit register access from core 0
//   or core 1. Each access yields exactly one beat on the rsp channel holding
//   the read data, both cores' interrupt levels, the wake pulses and the
//   bad-offset flag.
//   An accepted access is held in the request register while the register
//   state is updated and the result is formed; the result then moves into the
//   result register and appears on rsp. Throughput is one access per cycle
//   while rsp_ready stays high, set by the single request register feeding the
//   result register; mailbox head words are prefetched from the word RAMs so a
//   FIFO read does not have to wait for them.
//   When rsp_ready is low the result register holds its beat; one more access
//   can then wait in the request register, after which req_ready drops.
//   Synchronous reset clears the GPIO words, mailbox pointers and counts and
//   the sticky flags; mailbox word storage is not cleared and needs no
//   clearing pass, so the block accepts accesses right after reset.
module dual_core_gpio_and_mailbox_regs
  import dcgm_pkg::*;
#(
  parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  req_item_t  req_q;
  logic       req_q_valid;
  logic       load;
  logic [31:0] out_word;
  logic [31:0] out_word_next;
  logic [31:0] gpio_oe;
  logic [31:0] gpio_oe_next;
  logic [1:0]  ovf;
  logic [1:0]  ovf_next;
  logic [1:0]  unf;
  logic [1:0]  unf_next;
  mbox_ctrl_t  ctrl0;
  mbox_ctrl_t  ctrl1;
  mbox_stat_t  stat0;
  mbox_stat_t  stat1;
  mbox_stat_t  tx_stat;
  mbox_stat_t  rx_stat;
  logic        core;
  logic        push_ok;
  logic        pop_ok;
  logic [31:0] status_word;
  rsp_item_t   rsp_next;

  // Request register moves into the result register when that is free.
  assign load      = req_q_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !req_q_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req_ready) begin
      req_q_valid <= req_valid;
    end
    if (req_ready && req_valid) begin
      req_q <= req;
    end
  end

  // Mailbox c is filled by core c and drained by the other core.
  assign core    = req_q.requesting_core;
  assign tx_stat = core ? stat1 : stat0;
  assign rx_stat = core ? stat0 : stat1;

  assign status_word = {28'd0, unf[core], ovf[core], tx_stat.not_full, rx_stat.not_empty};

  // Access decode and next register state.
  always_comb begin
    out_word_next = out_word;
    gpio_oe_next  = gpio_oe;
    ovf_next      = ovf;
    unf_next      = unf;
    push_ok       = 1'b0;
    pop_ok        = 1'b0;
    rsp_next      = '0;
    if (req_q.command == CMD_READ) begin
      case (req_q.reg_offset)
        OFS_CPUID: rsp_next.read_data = {31'd0, core};
        OFS_OUT:   rsp_next.read_data = out_word;
        OFS_OE:    rsp_next.read_data = gpio_oe;
        OFS_FST:   rsp_next.read_data = status_word;
        OFS_FRD: begin
          if (rx_stat.not_empty) begin
            pop_ok             = 1'b1;
            rsp_next.read_data = rx_stat.head_word;
          end else begin
            unf_next[core] = 1'b1;
          end
        end
        OFS_SPIN:  rsp_next.read_data = '0;
        default:   rsp_next.bad_offset = 1'b1;
      endcase
    end else begin
      case (req_q.reg_offset)
        OFS_OUT:     out_word_next = req_q.write_data;
        OFS_OUT_SET: out_word_next = out_word | req_q.write_data;
        OFS_OUT_CLR: out_word_next = out_word & ~req_q.write_data;
        OFS_OUT_XOR: out_word_next = out_word ^ req_q.write_data;
        OFS_OE:      gpio_oe_next  = req_q.write_data;
        OFS_OE_SET:  gpio_oe_next  = gpio_oe | req_q.write_data;
        OFS_OE_CLR:  gpio_oe_next  = gpio_oe & ~req_q.write_data;
        OFS_OE_XOR:  gpio_oe_next  = gpio_oe ^ req_q.write_data;
        OFS_FST: begin
          if (req_q.write_data[ST_WOF_BIT]) begin
            ovf_next[core] = 1'b0;
          end
          if (req_q.write_data[ST_ROE_BIT]) begin
            unf_next[core] = 1'b0;
          end
        end
        OFS_FWR: begin
          if (tx_stat.not_full) begin
            push_ok = 1'b1;
          end else begin
            ovf_next[core] = 1'b1;
          end
        end
        default: rsp_next.bad_offset = 1'b1;
      endcase
    end
    // Interrupt levels and wake pulses reflect the state after the access.
    rsp_next.irq_core0  = stat1.not_empty_next || ovf_next[0] || unf_next[0];
    rsp_next.irq_core1  = stat0.not_empty_next || ovf_next[1] || unf_next[1];
    rsp_next.wake_core0 = ctrl1.push;
    rsp_next.wake_core1 = ctrl0.push;
  end

  // Mailbox operations, taken only when the access completes.
  always_comb begin
    ctrl0.wdata = req_q.write_data;
    ctrl1.wdata = req_q.write_data;
    ctrl0.push  = load && push_ok && !core;
    ctrl1.push  = load && push_ok && core;
    ctrl0.pop   = load && pop_ok && core;
    ctrl1.pop   = load && pop_ok && !core;
  end

  dcgm_mailbox #(
    .DEPTH(FIFO_DEPTH)
  ) u_mbox0 (
    .clk (clk),
    .rst (rst),
    .ctrl(ctrl0),
    .stat(stat0)
  );

  dcgm_mailbox #(
    .DEPTH(FIFO_DEPTH)
  ) u_mbox1 (
    .clk (clk),
    .rst (rst),
    .ctrl(ctrl1),
    .stat(stat1)
  );

  // Register state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_word  <= '0;
      gpio_oe   <= '0;
      ovf       <= '0;
      unf       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (load) begin
        out_word <= out_word_next;
        gpio_oe  <= gpio_oe_next;
        ovf      <= ovf_next;
        unf      <= unf_next;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (load) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ rtl/dcgm_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module dcgm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the address being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dcgm_mailbox.sv @@
// One-way mailbox FIFO: head pointer, fill count and a word store in a RAM.
// Depends on dcgm_pkg and dcgm_ram.
module dcgm_mailbox
  import dcgm_pkg::*;
#(
  parameter int DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  mbox_ctrl_t ctrl,
  output mbox_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [SW-1:0] slot_sum;
  logic [AW-1:0] slot;
  logic          byp_valid;
  logic [31:0]   byp_word;
  logic [31:0]   ram_rdata;

  // Write slot is head plus count, wrapped once at the depth.
  always_comb begin
    slot_sum = SW'(head) + SW'(count);
    if (slot_sum >= SW'(DEPTH)) begin
      slot = AW'(slot_sum - SW'(DEPTH));
    end else begin
      slot = AW'(slot_sum);
    end
  end

  // Pointer and count updates.
  always_comb begin
    head_next = head;
    if (ctrl.pop) begin
      if (head == AW'(DEPTH - 1)) begin
        head_next = '0;
      end else begin
        head_next = head + AW'(1);
      end
    end
    count_next = count;
    if (ctrl.push) begin
      count_next = count + CW'(1);
    end else if (ctrl.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      byp_valid <= 1'b0;
    end else begin
      head      <= head_next;
      count     <= count_next;
      byp_valid <= ctrl.push && (slot == head_next);
    end
    byp_word <= ctrl.wdata;
  end

  // The RAM always reads the upcoming head, so the head word is ready in the
  // next cycle. A push into the slot being read is forwarded around the RAM.
  dcgm_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctrl.push),
    .waddr(slot),
    .wdata(ctrl.wdata),
    .raddr(head_next),
    .rdata(ram_rdata)
  );

  assign stat.not_empty      = (count != '0);
  assign stat.not_full       = (count != CW'(DEPTH));
  assign stat.not_empty_next = (count_next != '0);
  assign stat.head_word      = byp_valid ? byp_word : ram_rdata;

endmodule

@@ tb/sv/dcgm_scoreboard.sv @@
// Checker for the dual-core GPIO and mailbox register block: watches both channels,
// predicts every access result and compares it with the response beat.
// Depends on dcgm_pkg for the beat structs, offsets and status bit positions.
`timescale 1ns / 100ps
module dcgm_scoreboard
  import dcgm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_ready,
  input  req_item_t req,
  input  logic      rsp_valid,
  input  logic      rsp_ready,
  input  rsp_item_t rsp,
  output int        fail_count,
  output int        outstanding
);

  localparam int DEPTH        = DEFAULT_FIFO_DEPTH;
  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the register state.
  logic [31:0] out_word;
  logic [31:0] gpio_oe;
  logic [31:0] mbox_word      [2][DEPTH];
  int unsigned mbox_head      [2];
  int unsigned mbox_count     [2];
  logic        overflow_flag  [2];
  logic        underflow_flag [2];

  rsp_item_t pending_results [$];
  int        failures = 0;
  int        pending_n = 0;

  assign fail_count  = failures;
  assign outstanding = pending_n;

  // Mailbox status word as seen by one core.
  function automatic logic [31:0] status_word(int core);
    logic [31:0] st;
    st = '0;
    st[ST_VLD_BIT] = (mbox_count[1 - core] != 0);
    st[ST_RDY_BIT] = (mbox_count[core] < DEPTH);
    st[ST_WOF_BIT] = overflow_flag[core];
    st[ST_ROE_BIT] = underflow_flag[core];
    return st;
  endfunction

  function automatic logic irq_level(int core);
    logic [31:0] st;
    st = status_word(core);
    return st[ST_VLD_BIT] | st[ST_WOF_BIT] | st[ST_ROE_BIT];
  endfunction

  // Applies one access to the shadow state and returns the result it should produce.
  function automatic rsp_item_t predict_access(req_item_t a);
    rsp_item_t   r;
    int          c;
    int          p;
    int unsigned slot;
    c = a.requesting_core;
    p = 1 - c;
    r = '0;
    if (a.command == CMD_READ) begin
      case (a.reg_offset)
        OFS_CPUID: r.read_data = 32'(c);
        OFS_OUT:   r.read_data = out_word;
        OFS_OE:    r.read_data = gpio_oe;
        OFS_FST:   r.read_data = status_word(c);
        OFS_FRD: begin
          if (mbox_count[p] == 0) begin
            underflow_flag[c] = 1'b1;
          end else begin
            r.read_data   = mbox_word[p][mbox_head[p]];
            mbox_head[p]  = (mbox_head[p] + 1) % DEPTH;
            mbox_count[p] = mbox_count[p] - 1;
          end
        end
        OFS_SPIN:  r.read_data = '0;
        default:   r.bad_offset = 1'b1;
      endcase
    end else begin
      case (a.reg_offset)
        OFS_OUT:     out_word = a.write_data;
        OFS_OUT_SET: out_word = out_word | a.write_data;
        OFS_OUT_CLR: out_word = out_word & ~a.write_data;
        OFS_OUT_XOR: out_word = out_word ^ a.write_data;
        OFS_OE:      gpio_oe = a.write_data;
        OFS_OE_SET:  gpio_oe = gpio_oe | a.write_data;
        OFS_OE_CLR:  gpio_oe = gpio_oe & ~a.write_data;
        OFS_OE_XOR:  gpio_oe = gpio_oe ^ a.write_data;
        OFS_FST: begin
          if (a.write_data[ST_WOF_BIT]) overflow_flag[c] = 1'b0;
          if (a.write_data[ST_ROE_BIT]) underflow_flag[c] = 1'b0;
        end
        OFS_FWR: begin
          if (mbox_count[c] >= DEPTH) begin
            overflow_flag[c] = 1'b1;
          end else begin
            slot = (mbox_head[c] + mbox_count[c]) % DEPTH;
            mbox_word[c][slot] = a.write_data;
            mbox_count[c] = mbox_count[c] + 1;
            if (p == 0) r.wake_core0 = 1'b1;
            else r.wake_core1 = 1'b1;
          end
        end
        default: r.bad_offset = 1'b1;
      endcase
    end
    r.irq_core0 = irq_level(0);
    r.irq_core1 = irq_level(1);
    return r;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  // Compare the response beat first, then predict the access beat of the same edge.
  always @(posedge clk) begin : monitor
    rsp_item_t exp_r;
    logic      field_bad;
    if (rst) begin
      out_word = '0;
      gpio_oe  = '0;
      for (int i = 0; i < 2; i++) begin
        mbox_head[i]      = 0;
        mbox_count[i]     = 0;
        overflow_flag[i]  = 1'b0;
        underflow_flag[i] = 1'b0;
      end
      pending_results.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          note_failure($sformatf("response beat with no access waiting: rd=%h", rsp.read_data));
        end else begin
          exp_r = pending_results.pop_front();
          field_bad = (rsp.read_data !== exp_r.read_data) ||
                      (rsp.irq_core0 !== exp_r.irq_core0) ||
                      (rsp.irq_core1 !== exp_r.irq_core1) ||
                      (rsp.wake_core0 !== exp_r.wake_core0) ||
                      (rsp.wake_core1 !== exp_r.wake_core1) ||
                      (rsp.bad_offset !== exp_r.bad_offset);
          if (field_bad) begin
            note_failure($sformatf(
              "exp rd=%h irq=%b%b wake=%b%b bad=%b / got rd=%h irq=%b%b wake=%b%b bad=%b",
              exp_r.read_data, exp_r.irq_core0, exp_r.irq_core1, exp_r.wake_core0,
              exp_r.wake_core1, exp_r.bad_offset, rsp.read_data, rsp.irq_core0,
              rsp.irq_core1, rsp.wake_core0, rsp.wake_core1, rsp.bad_offset));
          end
        end
      end
      if (req_valid && req_ready) pending_results.push_back(predict_access(req));
    end
    pending_n = pending_results.size();
  end

endmodule

@@ tb/sv/tb_dual_core_gpio_and_mailbox_regs.sv @@
// Testbench top for the dual-core GPIO and mailbox register block: clock, reset,
// access stimulus, response back-pressure, watchdog and verdict.
// Depends on dcgm_pkg, the block under test and dcgm_scoreboard.
`timescale 1ns / 100ps
module tb_dual_core_gpio_and_mailbox_regs
  import dcgm_pkg::*;
();

  localparam int RANDOM_ITEMS   = 2000;
  localparam int IDLE_PCT       = 13;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int END_LATENCY    = 8;
  localparam int HOLD_A         = 400;
  localparam int HOLD_A_LEN     = 60;
  localparam int HOLD_B         = 1700;
  localparam int HOLD_B_LEN     = 40;
  localparam int CALM_FROM      = 900;
  localparam int CALM_TO        = 1300;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_item_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_item_t rsp;
  int        fail_count;
  int        outstanding;
  bit        quiet_sender;
  int        push_pct;
  int        pop_pct;

  dual_core_gpio_and_mailbox_regs u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  dcgm_scoreboard u_scoreboard (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one access beat and holds it until accepted; returns at a falling edge.
  task automatic drive_access(input req_item_t a);
    while (!quiet_sender && $urandom_range(99) < IDLE_PCT) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req       = a;
    req_valid = 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic access(input logic cmd, input logic core, input logic [11:0] ofs,
                        input logic [31:0] data);
    req_item_t a;
    a.command         = cmd;
    a.requesting_core = core;
    a.reg_offset      = ofs;
    a.write_data      = data;
    drive_access(a);
  endtask

  // Stops offering beats until every predicted result has come back.
  task automatic drain_results();
    req_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Mailbox traffic steered by the current mix in half or more of the accesses, then GPIO, status and noise.
  function automatic req_item_t random_access();
    req_item_t a;
    int        roll;
    a.requesting_core = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       a.write_data = '0;
      1:       a.write_data = '1;
      default: a.write_data = $urandom;
    endcase
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      a.command    = CMD_WRITE;
      a.reg_offset = OFS_FWR;
    end else if (roll < push_pct + pop_pct) begin
      a.command    = CMD_READ;
      a.reg_offset = OFS_FRD;
    end else begin
      roll = $urandom_range(99);
      if (roll < 25) begin
        a.command    = 1'($urandom_range(1));
        a.reg_offset = OFS_FST;
      end else if (roll < 70) begin
        case ($urandom_range(9))
          0:       a.reg_offset = OFS_OUT;
          1:       a.reg_offset = OFS_OUT_SET;
          2:       a.reg_offset = OFS_OUT_CLR;
          3:       a.reg_offset = OFS_OUT_XOR;
          4:       a.reg_offset = OFS_OE;
          5:       a.reg_offset = OFS_OE_SET;
          6:       a.reg_offset = OFS_OE_CLR;
          7:       a.reg_offset = OFS_OE_XOR;
          8:       a.reg_offset = OFS_OUT;
          default: a.reg_offset = OFS_OE;
        endcase
        if (a.reg_offset == OFS_OUT || a.reg_offset == OFS_OE) a.command = 1'($urandom_range(1));
        else a.command = CMD_WRITE;
      end else if (roll < 80) begin
        a.command    = CMD_READ;
        a.reg_offset = ($urandom_range(1) != 0) ? OFS_CPUID : OFS_SPIN;
      end else if (roll < 90) begin
        // Known offsets with either access kind, so wrong-direction accesses show up.
        a.command = 1'($urandom_range(1));
        case ($urandom_range(5))
          0:       a.reg_offset = OFS_CPUID;
          1:       a.reg_offset = OFS_FWR;
          2:       a.reg_offset = OFS_FRD;
          3:       a.reg_offset = OFS_SPIN;
          4:       a.reg_offset = OFS_OE_SET;
          default: a.reg_offset = OFS_OUT_CLR;
        endcase
      end else begin
        a.command    = 1'($urandom_range(1));
        a.reg_offset = 12'($urandom_range(4095));
      end
    end
    return a;
  endfunction

  // Response side: random stalls, a calm window and two long hold-offs.
  initial begin : sink
    int cyc;
    rsp_ready = 1'b0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if ((cyc >= HOLD_A && cyc < HOLD_A + HOLD_A_LEN) ||
          (cyc >= HOLD_B && cyc < HOLD_B + HOLD_B_LEN)) begin
        rsp_ready = 1'b0;
      end else if (cyc >= CALM_FROM && cyc < CALM_TO) begin
        rsp_ready = 1'b1;
      end else begin
        rsp_ready = ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Ends the run when neither channel moves a beat for too long.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stalled = 0;
      else stalled++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    quiet_sender = 1'b0;
    push_pct     = 25;
    pop_pct      = 25;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Identity reads from both cores and a spinlock read.
    access(CMD_READ, 1'b0, OFS_CPUID, 32'hffff_ffff);
    access(CMD_READ, 1'b1, OFS_CPUID, 32'h0000_0000);
    access(CMD_READ, 1'b1, OFS_SPIN, 32'h0);
    // GPIO output and enable words through write, set, clear, toggle and read accesses between them.
    access(CMD_WRITE, 1'b0, OFS_OUT, 32'hffff_ffff);
    access(CMD_WRITE, 1'b1, OFS_OUT_CLR, 32'h0f0f_0f0f);
    access(CMD_WRITE, 1'b0, OFS_OUT_XOR, 32'hffff_0000);
    access(CMD_READ, 1'b1, OFS_OUT, 32'h0);
    access(CMD_WRITE, 1'b1, OFS_OE_SET, 32'h8000_0001);
    access(CMD_WRITE, 1'b0, OFS_OE_XOR, 32'hffff_ffff);
    access(CMD_READ, 1'b0, OFS_OE, 32'h0);
    // Underflow on an empty mailbox, then status read and sticky clear.
    access(CMD_READ, 1'b1, OFS_FRD, 32'h0);
    access(CMD_READ, 1'b1, OFS_FST, 32'h0);
    access(CMD_WRITE, 1'b1, OFS_FST, 32'hffff_ffff);
    // Unaligned offset, a write to a read-only register, a read of an unmapped offset.
    access(CMD_READ, 1'b0, 12'h011, 32'h0);
    access(CMD_WRITE, 1'b0, OFS_CPUID, 32'hffff_ffff);
    access(CMD_READ, 1'b1, 12'hfff, 32'h0);
    // Fill core 0's mailbox past full to hit the overflow case, then drain one word.
    for (int i = 0; i <= DEFAULT_FIFO_DEPTH; i++) begin
      access(CMD_WRITE, 1'b0, OFS_FWR, (i == 0) ? 32'hffff_ffff : $urandom);
    end
    access(CMD_READ, 1'b1, OFS_FRD, 32'h0);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Switch between filling, draining and balanced mailbox traffic.
      if (i % 64 == 0) begin
        case ($urandom_range(2))
          0: begin push_pct = 45; pop_pct = 10; end
          1: begin push_pct = 10; pop_pct = 45; end
          default: begin push_pct = 25; pop_pct = 25; end
        endcase
      end
      quiet_sender = (i >= 1200 && i < 1500);
      if (i == RANDOM_ITEMS / 2) drain_results();
      drive_access(random_access());
    end

    drain_results();
    repeat (END_LATENCY) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dcgm_pkg.sv
rtl/dcgm_ram.sv
rtl/dcgm_mailbox.sv
rtl/dual_core_gpio_and_mailbox_regs.sv
tb/sv/dcgm_scoreboard.sv
tb/sv/tb_dual_core_gpio_and_mailbox_regs.sv
